[hdl/vwfk_pkg.sv]
// ---------------------------------------------------------------------------
// vwfk_pkg
// Shared widths, register indexes, friction constants and stage records for
// the virtual wall force unit.
// ---------------------------------------------------------------------------
package vwfk_pkg;

  localparam int unsigned QW = 32;
  localparam int unsigned CW = 31;
  localparam int unsigned FW = 49;
  localparam int unsigned SPRING_W = 2 * CW - 16;
  localparam int unsigned DAMP_W = CW + QW - 16;
  localparam int unsigned SLOPE_W = 16;
  localparam int unsigned IN_TDATA_W = 4 * QW;
  localparam int unsigned OUT_TDATA_W = 72;
  localparam int unsigned CFG_ADDR_W = 3;

  localparam logic [CFG_ADDR_W-1:0] REG_WALL_HALF_X = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_WALL_HALF_Y = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_PROBE_RADIUS = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_WALL_STIFFNESS = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_WALL_DAMPING = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_STICK_BAND = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_COULOMB_POS = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_COULOMB_NEG = 3'd7;

  localparam logic [CW-1:0] RST_WALL_HALF_X = 31'd8192;
  localparam logic [CW-1:0] RST_WALL_HALF_Y = 31'd5243;
  localparam logic [CW-1:0] RST_PROBE_RADIUS = 31'd655;
  localparam logic [CW-1:0] RST_WALL_STIFFNESS = 31'd196608000;
  localparam logic [CW-1:0] RST_WALL_DAMPING = 31'd26214;
  localparam logic [CW-1:0] RST_STICK_BAND = 31'd459;
  localparam logic [CW-1:0] RST_COULOMB_POS = 31'd116090;
  localparam logic [CW-1:0] RST_COULOMB_NEG = 31'd113312;

  localparam logic signed [FW-1:0] STICK_POS = 49'sd139605;
  localparam logic signed [FW-1:0] STICK_NEG = -49'sd122048;
  localparam logic [SLOPE_W-1:0] SLOPE_POS = 16'd29950;
  localparam logic [SLOPE_W-1:0] SLOPE_NEG = 16'd40606;

  localparam logic signed [FW-1:0] Q_MAX = 49'sd2147483647;
  localparam logic signed [FW-1:0] Q_MIN = -49'sd2147483648;

  localparam logic [1:0] BAND_SLIDE_NEG = 2'd0;
  localparam logic [1:0] BAND_STICK_NEG = 2'd1;
  localparam logic [1:0] BAND_STICK_POS = 2'd2;
  localparam logic [1:0] BAND_SLIDE_POS = 2'd3;

  typedef struct packed {
    logic          contact;
    logic          d_pos;
    logic          damp_on;
    logic          vel_nz;
    logic [1:0]    band;
    logic [CW-1:0] gap;
    logic [QW-1:0] vel_mag;
  } geom_t;

  typedef struct packed {
    logic                contact;
    logic                d_pos;
    logic                damp_on;
    logic                vel_nz;
    logic [1:0]          band;
    logic [SPRING_W-1:0] spring;
    logic [DAMP_W-1:0]   damp;
    logic [QW-1:0]       slope;
  } prod_t;

  typedef struct packed {
    logic                   contact;
    logic [1:0]             band;
    logic signed [FW-1:0]   wall;
    logic signed [FW-1:0]   slide;
  } axis_t;

  function automatic logic signed [QW-1:0] sat_q(input logic signed [FW-1:0] v);
    logic signed [FW-1:0] r;
    r = v;
    if (v > Q_MAX) r = Q_MAX;
    if (v < Q_MIN) r = Q_MIN;
    return r[QW-1:0];
  endfunction

endpackage

[hdl/vwfk_geom.sv]
// ---------------------------------------------------------------------------
// vwfk_geom
// Stage 1 of one axis: nearer wall, contact test, gap, damping condition and
// Karnopp velocity band.
// ---------------------------------------------------------------------------
module vwfk_geom import vwfk_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [QW-1:0] pos,
  input  logic signed [QW-1:0] vel,
  input  logic [CW-1:0]        half,
  input  logic [CW-1:0]        radius,
  input  logic [CW-1:0]        stick,
  output geom_t                geom
);

  logic signed [QW:0] pos_w;
  logic signed [QW:0] half_w;
  logic signed [QW:0] e_near;
  logic [QW:0]        dm;
  logic signed [QW:0] vel_w;
  logic signed [QW:0] band_w;
  geom_t              geom_next;

  always_comb begin
    pos_w  = {pos[QW-1], pos};
    half_w = $signed({2'b00, half});
    vel_w  = {vel[QW-1], vel};
    band_w = $signed({2'b00, stick});
    if (pos > 0 && half != '0) begin
      e_near = pos_w - half_w;
    end else begin
      e_near = pos_w + half_w;
    end
    dm = e_near[QW] ? (QW+1)'(-e_near) : e_near;
    geom_next.contact = dm < {2'b00, radius};
    geom_next.gap     = radius - dm[CW-1:0];
    geom_next.d_pos   = !e_near[QW] && (e_near != '0);
    geom_next.damp_on = (geom_next.d_pos && vel[QW-1]) ||
                        (e_near[QW] && !vel[QW-1] && vel != '0);
    geom_next.vel_mag = vel[QW-1] ? QW'(-vel) : vel;
    geom_next.vel_nz  = vel != '0;
    if (vel_w < -band_w) begin
      geom_next.band = BAND_SLIDE_NEG;
    end else if (vel[QW-1]) begin
      geom_next.band = BAND_STICK_NEG;
    end else if (vel_w < band_w) begin
      geom_next.band = BAND_STICK_POS;
    end else begin
      geom_next.band = BAND_SLIDE_POS;
    end
  end

  always_ff @(posedge clk) begin
    if (en) geom <= geom_next;
  end

endmodule

[hdl/vwfk_mul.sv]
// ---------------------------------------------------------------------------
// vwfk_mul
// Stage 2 of one axis: spring, damping and sliding-slope products, each
// truncated by the 16 fraction bits.
// ---------------------------------------------------------------------------
module vwfk_mul import vwfk_pkg::*; (
  input  logic          clk,
  input  logic          en,
  input  geom_t         geom,
  input  logic [CW-1:0] stiffness,
  input  logic [CW-1:0] damping,
  output prod_t         prod
);

  logic [2*CW-1:0]       spring_full;
  logic [CW+QW-1:0]      damp_full;
  logic [SLOPE_W+QW-1:0] slope_full;
  logic [SLOPE_W-1:0]    slope_gain;
  prod_t                 prod_next;

  always_comb begin
    slope_gain  = (geom.band == BAND_SLIDE_NEG) ? SLOPE_NEG : SLOPE_POS;
    spring_full = stiffness * geom.gap;
    damp_full   = damping * geom.vel_mag;
    slope_full  = slope_gain * geom.vel_mag;
    prod_next.contact = geom.contact;
    prod_next.d_pos   = geom.d_pos;
    prod_next.damp_on = geom.damp_on;
    prod_next.vel_nz  = geom.vel_nz;
    prod_next.band    = geom.band;
    prod_next.spring  = spring_full[2*CW-1:16];
    prod_next.damp    = damp_full[CW+QW-1:16];
    prod_next.slope   = slope_full[SLOPE_W+QW-1:16];
  end

  always_ff @(posedge clk) begin
    if (en) prod <= prod_next;
  end

endmodule

[hdl/vwfk_force.sv]
// ---------------------------------------------------------------------------
// vwfk_force
// Stage 3 of one axis: signed wall force with damping, and the sliding
// friction force for the outer velocity bands.
// ---------------------------------------------------------------------------
module vwfk_force import vwfk_pkg::*; (
  input  logic          clk,
  input  logic          en,
  input  prod_t         prod,
  input  logic [CW-1:0] coulomb_pos,
  input  logic [CW-1:0] coulomb_neg,
  output axis_t         axis
);

  logic signed [FW-1:0] spring_s;
  logic signed [FW-1:0] damp_s;
  logic signed [FW-1:0] slope_s;
  logic signed [FW-1:0] cp_s;
  logic signed [FW-1:0] cn_s;
  axis_t                axis_next;

  always_comb begin
    spring_s = $signed({{(FW-SPRING_W){1'b0}}, prod.spring});
    damp_s   = $signed({{(FW-DAMP_W){1'b0}}, prod.damp});
    slope_s  = $signed({{(FW-QW){1'b0}}, prod.slope});
    cp_s     = $signed({{(FW-CW){1'b0}}, coulomb_pos});
    cn_s     = $signed({{(FW-CW){1'b0}}, coulomb_neg});
    axis_next.contact = prod.contact;
    axis_next.band    = prod.band;
    axis_next.wall    = '0;
    if (prod.contact) begin
      axis_next.wall = (prod.d_pos ? spring_s : -spring_s) +
                       (prod.damp_on ? damp_s : '0);
    end
    if (prod.band == BAND_SLIDE_NEG) begin
      axis_next.slide = -cn_s - slope_s;
    end else begin
      axis_next.slide = (prod.vel_nz ? cp_s : '0) + slope_s;
    end
  end

  always_ff @(posedge clk) begin
    if (en) axis <= axis_next;
  end

endmodule

[hdl/vwfk_out.sv]
// ---------------------------------------------------------------------------
// vwfk_out
// Stage 4: cross-axis Karnopp selection, saturation and the output register.
// ---------------------------------------------------------------------------
module vwfk_out import vwfk_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  axis_t                ax,
  input  axis_t                ay,
  output logic signed [QW-1:0] force_x,
  output logic signed [QW-1:0] force_y,
  output logic                 touch_x,
  output logic                 touch_y
);

  function automatic logic signed [FW-1:0] karnopp(input axis_t a);
    logic signed [FW-1:0] r;
    case (a.band) inside
      BAND_SLIDE_NEG, BAND_SLIDE_POS: r = a.slide;
      BAND_STICK_NEG:                 r = (a.wall > STICK_NEG) ? a.wall : STICK_NEG;
      default:                        r = (a.wall < STICK_POS) ? a.wall : STICK_POS;
    endcase
    return r;
  endfunction

  logic signed [FW-1:0] fx;
  logic signed [FW-1:0] fy;

  always_comb begin
    fx = ay.contact ? karnopp(ax) : ax.wall;
    fy = ax.contact ? karnopp(ay) : ay.wall;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      force_x <= sat_q(fx);
      force_y <= sat_q(fy);
      touch_x <= ax.contact;
      touch_y <= ay.contact;
    end
  end

endmodule

[hdl/virtual_wall_force_karnopp_unit.sv]
// ---------------------------------------------------------------------------
// virtual_wall_force_karnopp_unit
// Virtual wall force with Karnopp friction, four-stage pipeline.
//
//   port group   dir   contents (lowest bits first)
//   s_axis_*     in    pos_x, pos_y, vel_x, vel_y
//   m_axis_*     out   force_x, force_y, touch_x_wall, touch_y_wall, zero pad
//   cfg_*        in    register index, 31-bit value
//
// One beat enters per cycle unless a stall on m_axis_tready has filled every stage.
// Depth is set by the four register stages: geometry, multipliers,
// force sum, friction select and saturation.
// rst clears the stage valids and reloads every config register's reset value.
// A stall backs up stage by stage; empty stages keep filling meanwhile.
// ---------------------------------------------------------------------------
module virtual_wall_force_karnopp_unit import vwfk_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // pos_x, pos_y, vel_x, vel_y
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // force_x, force_y, touch_x, touch_y
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CW-1:0]          cfg_wdata
);

  logic [CW-1:0] wall_half_x;
  logic [CW-1:0] wall_half_y;
  logic [CW-1:0] probe_radius;
  logic [CW-1:0] wall_stiffness;
  logic [CW-1:0] wall_damping;
  logic [CW-1:0] stick_band;
  logic [CW-1:0] coulomb_positive;
  logic [CW-1:0] coulomb_negative;

  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;

  geom_t geom_x, geom_y;
  prod_t prod_x, prod_y;
  axis_t axis_x, axis_y;

  logic signed [QW-1:0] force_x;
  logic signed [QW-1:0] force_y;
  logic                 touch_x;
  logic                 touch_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      wall_half_x      <= RST_WALL_HALF_X;
      wall_half_y      <= RST_WALL_HALF_Y;
      probe_radius     <= RST_PROBE_RADIUS;
      wall_stiffness   <= RST_WALL_STIFFNESS;
      wall_damping     <= RST_WALL_DAMPING;
      stick_band       <= RST_STICK_BAND;
      coulomb_positive <= RST_COULOMB_POS;
      coulomb_negative <= RST_COULOMB_NEG;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_WALL_HALF_X:    wall_half_x      <= cfg_wdata;
        REG_WALL_HALF_Y:    wall_half_y      <= cfg_wdata;
        REG_PROBE_RADIUS:   probe_radius     <= cfg_wdata;
        REG_WALL_STIFFNESS: wall_stiffness   <= cfg_wdata;
        REG_WALL_DAMPING:   wall_damping     <= cfg_wdata;
        REG_STICK_BAND:     stick_band       <= cfg_wdata;
        REG_COULOMB_POS:    coulomb_positive <= cfg_wdata;
        REG_COULOMB_NEG:    coulomb_negative <= cfg_wdata;
      endcase
    end
  end

  assign en4 = !v4 || m_axis_tready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign s_axis_tready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= s_axis_tvalid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  vwfk_geom u_geom_x (
    .clk    (clk),
    .en     (en1),
    .pos    (s_axis_tdata[QW-1:0]),
    .vel    (s_axis_tdata[3*QW-1:2*QW]),
    .half   (wall_half_x),
    .radius (probe_radius),
    .stick  (stick_band),
    .geom   (geom_x)
  );

  vwfk_geom u_geom_y (
    .clk    (clk),
    .en     (en1),
    .pos    (s_axis_tdata[2*QW-1:QW]),
    .vel    (s_axis_tdata[4*QW-1:3*QW]),
    .half   (wall_half_y),
    .radius (probe_radius),
    .stick  (stick_band),
    .geom   (geom_y)
  );

  vwfk_mul u_mul_x (
    .clk       (clk),
    .en        (en2),
    .geom      (geom_x),
    .stiffness (wall_stiffness),
    .damping   (wall_damping),
    .prod      (prod_x)
  );

  vwfk_mul u_mul_y (
    .clk       (clk),
    .en        (en2),
    .geom      (geom_y),
    .stiffness (wall_stiffness),
    .damping   (wall_damping),
    .prod      (prod_y)
  );

  vwfk_force u_force_x (
    .clk         (clk),
    .en          (en3),
    .prod        (prod_x),
    .coulomb_pos (coulomb_positive),
    .coulomb_neg (coulomb_negative),
    .axis        (axis_x)
  );

  vwfk_force u_force_y (
    .clk         (clk),
    .en          (en3),
    .prod        (prod_y),
    .coulomb_pos (coulomb_positive),
    .coulomb_neg (coulomb_negative),
    .axis        (axis_y)
  );

  vwfk_out u_out (
    .clk     (clk),
    .en      (en4),
    .ax      (axis_x),
    .ay      (axis_y),
    .force_x (force_x),
    .force_y (force_y),
    .touch_x (touch_x),
    .touch_y (touch_y)
  );

  assign m_axis_tvalid = v4;
  assign m_axis_tdata  = {{(OUT_TDATA_W-2*QW-2){1'b0}}, touch_y, touch_x, force_y, force_x};

endmodule

[hdl/vwfk_checker.sv]
// ---------------------------------------------------------------------------
// vwfk_checker
// Port-level checks for the virtual wall force unit, bound to the top level.
// ---------------------------------------------------------------------------
module vwfk_checker import vwfk_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output beat valid right after reset");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output beat changed");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with an empty output stage");

  a_no_touch_no_force: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[2*QW] && !m_axis_tdata[2*QW+1]
      |-> m_axis_tdata[2*QW-1:0] == '0)
    else $error("force without wall contact");

endmodule

bind virtual_wall_force_karnopp_unit vwfk_checker u_vwfk_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
